/* hw/rtl/lqsm_pkg.sv */
// Shared types and constants of the linear queue with search and max.
package lqsm_pkg;

  localparam int DEPTH_DEF = 128;
  localparam int WORD_W    = 32;
  localparam int REQ_W     = 2;
  localparam int STAT_W    = 2;
  localparam int IDX_W     = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_ENQ    = 2'd0,
    REQ_DEQ    = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_MAX    = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Flags from the shared compare unit.
  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

/* hw/rtl/lqsm_if.sv */
// Valid/ready channel interfaces for requests and results.
interface lqsm_in_if;
  import lqsm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface lqsm_out_if;
  import lqsm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [WORD_W-1:0] data_out;
  logic [IDX_W-1:0]         found_index;

  modport source (output valid, output status, output data_out, output found_index,
                  input ready);
  modport sink   (input valid, input status, input data_out, input found_index,
                  output ready);
endinterface

/* hw/rtl/lqsm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lqsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/lqsm_cmp.sv */
// Shared compare unit: equality and signed greater-than of two words.
module lqsm_cmp (
  input  logic signed [lqsm_pkg::WORD_W-1:0] a,
  input  logic signed [lqsm_pkg::WORD_W-1:0] b,
  output lqsm_pkg::cmp_res_t                 res
);
  import lqsm_pkg::*;

  assign res.eq = (a == b);
  assign res.gt = (a > b);

endmodule

/* hw/rtl/linear_queue_search_max.sv */
// Top level: linear queue of signed words with enqueue, dequeue, search and max.
//
// A linear (non-circular) queue of DEPTH signed 32-bit words held in one RAM
// with a single read port and registered read data. Each request transaction
// yields exactly one result transaction. Enqueue reports full once the tail
// sits on the last slot, even if the head has moved on; dequeuing the last
// word returns both indices to slot 0. Search walks from head to tail and
// returns the absolute slot of the first match (truncated to 7 bits); the max
// query walks the same slots. The block takes one request at a time and is
// not ready until that request's result has been loaded into the output
// register; the output register lets a finished result wait while the next
// request is taken. Enqueue, and any request on an empty queue, go from
// idle straight to the emit state; dequeue takes the head word in the scan
// state; search and max visit the slots from the head onward, at most
// tail - head + 1 of them, so up to DEPTH. The scan rate is one word per cycle,
// set by the RAM read port feeding the shared compare unit. The block also
// stays busy while a finished result waits behind a stalled output register.
// No clearing pass is needed after reset.
module linear_queue_search_max #(
  parameter int DEPTH = lqsm_pkg::DEPTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  lqsm_in_if.sink    in_ch,
  lqsm_out_if.source out_ch
);
  import lqsm_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,  // waiting for a request
    S_SCAN = 3'b010,  // one RAM word per cycle into the compare unit
    S_EMIT = 3'b100   // result waits for the output register
  } state_t;

  state_t state_r, state_nxt;

  // Queue bookkeeping
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic          empty_r, empty_nxt;

  // Per-request working registers
  logic [AW-1:0]            cur_r, cur_nxt;     // slot whose data is on rd_data
  req_t                     op_r, op_nxt;
  logic signed [WORD_W-1:0] key_r, key_nxt;
  logic signed [WORD_W-1:0] best_r, best_nxt;
  logic                     first_r, first_nxt;

  // Pending result
  status_t                  res_status_r, res_status_nxt;
  logic signed [WORD_W-1:0] res_data_r, res_data_nxt;
  logic [IDX_W-1:0]         res_idx_r, res_idx_nxt;

  // Output register
  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic signed [WORD_W-1:0] out_data_r, out_data_nxt;
  logic [IDX_W-1:0]         out_idx_r, out_idx_nxt;

  // RAM port
  logic                     we;
  logic [AW-1:0]            waddr;
  logic [AW-1:0]            raddr;
  logic [WORD_W-1:0]        rd_word;
  logic signed [WORD_W-1:0] rd_data;

  // Shared compare unit
  logic signed [WORD_W-1:0] cmp_b;
  cmp_res_t                 cmp_res;

  logic                     in_accept;
  logic                     last_slot;
  logic [AW-1:0]            cur_inc;
  logic [AW-1:0]            tail_inc;
  logic signed [WORD_W-1:0] best_sel;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;

  assign rd_data   = $signed(rd_word);
  assign last_slot = (cur_r == tail_r);
  assign cur_inc   = AW'(cur_r + 1'b1);
  assign tail_inc  = AW'(tail_r + 1'b1);
  // Search compares against the key, max against the running best.
  assign cmp_b     = (op_r == REQ_SEARCH) ? key_r : best_r;
  assign best_sel  = (first_r || cmp_res.gt) ? rd_data : best_r;

  lqsm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_ch.value),
    .raddr (raddr),
    .rdata (rd_word)
  );

  lqsm_cmp u_cmp (
    .a   (rd_data),
    .b   (cmp_b),
    .res (cmp_res)
  );

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    empty_nxt      = empty_r;
    cur_nxt        = cur_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    best_nxt       = best_r;
    first_nxt      = first_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    res_idx_nxt    = res_idx_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_idx_nxt    = out_idx_r;
    we             = 1'b0;
    waddr          = tail_inc;
    // Prefetch the next slot while scanning.
    raddr          = cur_inc;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        raddr = head_r;
        if (in_accept) begin
          cur_nxt        = head_r;
          op_nxt         = req_t'(in_ch.req_type);
          key_nxt        = in_ch.value;
          first_nxt      = 1'b1;
          res_status_nxt = ST_OK;
          res_data_nxt   = '0;
          res_idx_nxt    = '0;
          if (req_t'(in_ch.req_type) == REQ_ENQ) begin
            state_nxt = S_EMIT;
            if (empty_r) begin
              we        = 1'b1;
              waddr     = '0;
              head_nxt  = '0;
              tail_nxt  = '0;
              empty_nxt = 1'b0;
            end else if (tail_r == LAST_SLOT) begin
              res_status_nxt = ST_FULL;
            end else begin
              we       = 1'b1;
              tail_nxt = tail_inc;
            end
          end else if (empty_r) begin
            res_status_nxt = ST_EMPTY;
            state_nxt      = S_EMIT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        unique case (op_r)
          REQ_DEQ: begin
            res_data_nxt = rd_data;
            state_nxt    = S_EMIT;
            if (head_r == tail_r) begin
              head_nxt  = '0;
              tail_nxt  = '0;
              empty_nxt = 1'b1;
            end else begin
              head_nxt = AW'(head_r + 1'b1);
            end
          end
          REQ_SEARCH: begin
            if (cmp_res.eq) begin
              res_idx_nxt = IDX_W'(cur_r);
              state_nxt   = S_EMIT;
            end else if (last_slot) begin
              res_status_nxt = ST_NOTFOUND;
              state_nxt      = S_EMIT;
            end else begin
              cur_nxt = cur_inc;
            end
          end
          REQ_MAX: begin
            best_nxt  = best_sel;
            first_nxt = 1'b0;
            if (last_slot) begin
              res_data_nxt = best_sel;
              state_nxt    = S_EMIT;
            end else begin
              cur_nxt = cur_inc;
            end
          end
          REQ_ENQ: begin
            // enqueue never scans
            state_nxt = S_EMIT;
          end
        endcase
      end

      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_data_nxt   = res_data_r;
          out_idx_nxt    = res_idx_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    best_r       <= best_nxt;
    first_r      <= first_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    res_idx_r    <= res_idx_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_idx_r    <= out_idx_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.data_out    = out_data_r;
  assign out_ch.found_index = out_idx_r;

  // Empty queue always parks both indices at slot 0.
  a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> (head_r == '0) && (tail_r == '0))
    else $error("empty queue with nonzero index");

  // A linear queue never has its head past its tail.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    !empty_r |-> (head_r <= tail_r))
    else $error("head past tail");

  // Scan pointer stays within the occupied slots.
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !empty_r && (cur_r >= head_r) && (cur_r <= tail_r))
    else $error("scan pointer out of range");

  // Every accepted transaction leaves idle on the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r != S_IDLE))
    else $error("sequencer stayed idle after accept");

endmodule

/* test/linear_queue_search_max_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the linear queue with search and max queries.
module linear_queue_search_max_test;
  import lqsm_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int N_ITEMS    = 1300;
  // Longest quiet stretch on a correct run is a full scan plus the longest
  // sender gap and the longest receiver stall; take it many times over.
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 10;

  // One result transaction as the queue should report it.
  typedef struct {
    status_t                  status;
    logic signed [WORD_W-1:0] data;
    logic [IDX_W-1:0]         index;
  } queue_reply_t;

  // Shadow copy of the queue plus the list of replies still owed by the block.
  class queue_scoreboard;
    logic signed [WORD_W-1:0] slots [DEPTH];
    int                       head;
    int                       tail;
    bit                       empty;
    queue_reply_t             owed_replies[$];
    int                       errors;

    function new();
      head   = 0;
      tail   = 0;
      empty  = 1;
      errors = 0;
    endfunction

    task report(string what);
      errors++;
      $display("ERROR @%0t: %s", $time, what);
    endtask

    // Apply one request to the shadow queue and return the reply it earns.
    function queue_reply_t apply_request(req_t req, logic signed [WORD_W-1:0] word);
      queue_reply_t r;
      bit           hit;
      r   = '{ST_OK, '0, '0};
      hit = 0;
      if (req == REQ_ENQ) begin
        if (empty) begin
          // first word always lands in slot 0
          head     = 0;
          tail     = 0;
          slots[0] = word;
          empty    = 0;
        end else if (tail == DEPTH - 1) begin
          r.status = ST_FULL;
        end else begin
          tail++;
          slots[tail] = word;
        end
      end else if (empty) begin
        r.status = ST_EMPTY;
      end else begin
        case (req)
          REQ_DEQ: begin
            r.data = slots[head];
            if (head == tail) begin
              head  = 0;
              tail  = 0;
              empty = 1;
            end else begin
              head++;
            end
          end
          REQ_SEARCH: begin
            r.status = ST_NOTFOUND;
            for (int i = head; i <= tail; i++) begin
              if (!hit && slots[i] == word) begin
                hit      = 1;
                r.status = ST_OK;
                r.index  = i[IDX_W-1:0];
              end
            end
          end
          default: begin
            r.data = slots[head];
            for (int i = head + 1; i <= tail; i++)
              if (slots[i] > r.data) r.data = slots[i];
          end
        endcase
      end
      return r;
    endfunction

    function void note_request(req_t req, logic signed [WORD_W-1:0] word);
      owed_replies.push_back(apply_request(req, word));
    endfunction

    task check_result(logic [STAT_W-1:0] status, logic signed [WORD_W-1:0] data,
                      logic [IDX_W-1:0] index);
      queue_reply_t want;
      if (owed_replies.size() == 0) begin
        report($sformatf("unexpected result status=%0d data=%0d index=%0d",
                         status, data, index));
      end else begin
        want = owed_replies.pop_front();
        if (status !== want.status)
          report($sformatf("status %0d, expected %0d", status, want.status));
        if (data !== want.data)
          report($sformatf("data_out %0d, expected %0d", data, want.data));
        if (index !== want.index)
          report($sformatf("found_index %0d, expected %0d", index, want.index));
      end
    endtask

    task flush_leftovers();
      queue_reply_t want;
      while (owed_replies.size() > 0) begin
        want = owed_replies.pop_front();
        report($sformatf("missing result status=%0d data=%0d index=%0d",
                         want.status, want.data, want.index));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  lqsm_in_if  req_ch ();
  lqsm_out_if res_ch ();

  linear_queue_search_max #(.DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch.sink),
    .out_ch (res_ch.source)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  queue_scoreboard sb = new();

  int sent    = 0;
  int results = 0;
  bit in_calm  = 0;   // sender runs back to back while set
  bit out_calm = 0;   // receiver never stalls while set
  bit armed    = 0;
  int quiet    = 0;

  // Watchdog: any transaction on either channel resets the quiet count.
  always @(posedge clk) begin
    if (armed) begin
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= IDLE_LIMIT) begin
        $display("linear_queue_search_max_test failed");
        $finish;
      end
    end
  end

  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  // Word source: full random, sign/range extremes, a tiny pool that forces
  // duplicates (first-match rule), or for searches a word known to be queued.
  function automatic logic signed [WORD_W-1:0] pick_word(bit for_search);
    logic signed [WORD_W-1:0] w;
    case ($urandom_range(0, 3))
      0: w = $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: w = 32'sh8000_0000;
          1: w = 32'sh7FFF_FFFF;
          2: w = 0;
          3: w = -1;
          default: w = 1;
        endcase
      end
      2: w = $urandom_range(0, 7);
      default: begin
        if (for_search && !sb.empty)
          w = sb.slots[$urandom_range(sb.tail, sb.head)];
        else
          w = $urandom;
      end
    endcase
    return w;
  endfunction

  // Present one request after a random gap and hold it until accepted.
  // Inputs move on the falling edge; acceptance is judged at the rising edge.
  task automatic send_request(input req_t req, input logic signed [WORD_W-1:0] word);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.req_type = req;
    req_ch.value    = word;
    req_ch.valid    = 1'b1;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    sb.note_request(req, word);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_query();
    if ($urandom_range(0, 1))
      send_request(REQ_SEARCH, pick_word(1));
    else
      send_request(REQ_MAX, 0);
  endtask

  // Result side: random stall before each transaction, then wait for valid.
  task automatic collect_results();
    int stall;
    forever begin
      stall = draw_gap(out_calm);
      if (stall > 0) begin
        res_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready = 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
      sb.check_result(res_ch.status, res_ch.data_out, res_ch.found_index);
      results++;
      if (results % 32 == 0) out_calm = ($urandom_range(0, 3) == 0);
      @(negedge clk);
    end
  endtask

  // Short directed run: empty-queue requests, extreme words, duplicate
  // search, signed max, draining to empty and refilling from slot 0.
  task automatic run_directed();
    send_request(REQ_DEQ, 0);
    send_request(REQ_SEARCH, 0);
    send_request(REQ_MAX, 32'sh7FFF_FFFF);
    send_request(REQ_ENQ, 32'sh8000_0000);
    send_request(REQ_MAX, 0);                 // single word, most negative
    send_request(REQ_ENQ, 32'sh7FFF_FFFF);
    send_request(REQ_ENQ, -1);
    send_request(REQ_ENQ, 0);
    send_request(REQ_ENQ, -1);                // duplicate
    send_request(REQ_SEARCH, -1);             // first match wins
    send_request(REQ_SEARCH, 32'sh7FFF_FFFF);
    send_request(REQ_SEARCH, 32'sh8000_0000);
    send_request(REQ_SEARCH, 12345);          // no match
    send_request(REQ_MAX, 0);
    send_request(REQ_DEQ, 0);
    send_request(REQ_SEARCH, 32'sh8000_0000); // already dequeued
    send_request(REQ_MAX, 0);
    repeat (4) send_request(REQ_DEQ, 0);      // last one empties the queue
    send_request(REQ_DEQ, 0);
    send_request(REQ_MAX, 0);
    send_request(REQ_ENQ, 5);                 // refill starts at slot 0
    send_request(REQ_SEARCH, 5);
  endtask

  // Random run built from phases: fill to full (with head often advanced,
  // so full comes early), drain to empty, and free mixes.
  task automatic run_random();
    int kind;
    while (sent < N_ITEMS) begin
      kind    = $urandom_range(0, 9);
      in_calm = ($urandom_range(0, 3) == 0);
      if (kind <= 2) begin
        while (sb.empty || sb.tail != DEPTH - 1) begin
          if ($urandom_range(0, 6) == 0) send_query();
          else send_request(REQ_ENQ, pick_word(0));
        end
        repeat ($urandom_range(1, 3)) send_request(REQ_ENQ, pick_word(0));
        send_request(REQ_SEARCH, sb.slots[DEPTH-1]);
        send_request(REQ_MAX, 0);
      end else if (kind <= 5) begin
        while (!sb.empty) begin
          if ($urandom_range(0, 6) == 0) send_query();
          else send_request(REQ_DEQ, 0);
        end
        repeat ($urandom_range(1, 2))
          send_request(req_t'($urandom_range(1, 3)), pick_word(1));
      end else begin
        repeat ($urandom_range(20, 60))
          send_request(req_t'($urandom_range(0, 3)), pick_word(1));
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_ENQ;
    req_ch.value    = '0;
    res_ch.ready    = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    armed = 1;

    fork
      collect_results();
    join_none

    run_directed();
    run_random();
    req_ch.valid = 1'b0;

    // Wait for every owed result, then wait out the drain window for strays.
    while (sb.owed_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    sb.flush_leftovers();

    if (sb.errors == 0)
      $display("linear_queue_search_max_test passed");
    else
      $display("linear_queue_search_max_test failed");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/lqsm_pkg.sv
hw/rtl/lqsm_if.sv
hw/rtl/lqsm_ram.sv
hw/rtl/lqsm_cmp.sv
hw/rtl/linear_queue_search_max.sv
test/linear_queue_search_max_test.sv
